FILE: rtl/core/skbc_pkg.sv
// ----------------------------------------------------------------------------
// Soft-knee band compressor package
// Shared types, register indexes, datapath operation codes and constants.
// ----------------------------------------------------------------------------
package skbc_pkg;

  // Sample format is signed Q1.(SAMPLE_BITS-1).
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  // Configuration port geometry.
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLOPE     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KNEE      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAKEUP    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE    = 3'd6;

  // Register reset values.
  localparam logic signed [10:0] RST_THRESHOLD = -11'sd320;
  localparam logic [15:0]        RST_SLOPE     = 16'd43691;
  localparam logic [7:0]         RST_KNEE      = 8'd96;
  localparam logic [8:0]         RST_MAKEUP    = 9'd0;
  localparam logic [23:0]        RST_ATTACK    = 24'd16742300;
  localparam logic [23:0]        RST_RELEASE   = 24'd16773721;
  localparam logic               RST_ENABLE    = 1'b1;

  // Arithmetic constants.
  localparam logic [14:0]        LOG_CORR     = 15'd22713;
  localparam logic [22:0]        DB_PER_LOG2  = 23'd6313041;
  localparam logic [17:0]        LOG2_PER_DB  = 18'd174165;
  localparam logic [14:0]        EXP_CORR     = 15'd22489;
  localparam logic signed [11:0] DB_FLOOR     = -12'sd1600;
  localparam logic [12:0]        DB_FLOOR_MAG = 13'd1600;
  localparam logic [9:0]         RED_MAX      = 10'd960;

  // Iteration counts of the multi-cycle steps.
  localparam int NORM_STEPS = 5;
  localparam int DIV_STEPS  = 9;

  // Datapath operation codes.
  localparam int OP_BITS = 5;
  localparam logic [OP_BITS-1:0] OP_NOP    = 5'd0;
  localparam logic [OP_BITS-1:0] OP_ACCEPT = 5'd1;
  localparam logic [OP_BITS-1:0] OP_ENV    = 5'd2;
  localparam logic [OP_BITS-1:0] OP_ENVW   = 5'd3;
  localparam logic [OP_BITS-1:0] OP_NORM   = 5'd4;
  localparam logic [OP_BITS-1:0] OP_LOG1   = 5'd5;
  localparam logic [OP_BITS-1:0] OP_LOG2   = 5'd6;
  localparam logic [OP_BITS-1:0] OP_LOG3   = 5'd7;
  localparam logic [OP_BITS-1:0] OP_LOG4   = 5'd8;
  localparam logic [OP_BITS-1:0] OP_LOG5   = 5'd9;
  localparam logic [OP_BITS-1:0] OP_RED    = 5'd10;
  localparam logic [OP_BITS-1:0] OP_LIN    = 5'd11;
  localparam logic [OP_BITS-1:0] OP_CUB    = 5'd12;
  localparam logic [OP_BITS-1:0] OP_CS     = 5'd13;
  localparam logic [OP_BITS-1:0] OP_NUM    = 5'd14;
  localparam logic [OP_BITS-1:0] OP_DIV    = 5'd15;
  localparam logic [OP_BITS-1:0] OP_GAIN1  = 5'd16;
  localparam logic [OP_BITS-1:0] OP_GAIN2  = 5'd17;
  localparam logic [OP_BITS-1:0] OP_GAIN3  = 5'd18;
  localparam logic [OP_BITS-1:0] OP_GAIN4  = 5'd19;
  localparam logic [OP_BITS-1:0] OP_MUL    = 5'd20;
  localparam logic [OP_BITS-1:0] OP_SHIFT  = 5'd21;
  localparam logic [OP_BITS-1:0] OP_LOAD   = 5'd22;

  // Input item.
  typedef struct packed {
    logic                          chan;
    logic signed [SAMPLE_BITS-1:0] in_sample;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic [9:0]                    reduction_db;
  } out_item_t;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [10:0] threshold_db;
    logic [15:0]        ratio_slope;
    logic [7:0]         knee_db;
    logic [8:0]         makeup_db;
    logic [23:0]        attack_coeff;
    logic [23:0]        release_coeff;
    logic               enable;
  } cfg_t;

  // Controller to datapath command.
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [3:0]         step;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic bypass;
    logic red_zero;
    logic in_knee;
  } dp_status_t;

endpackage

FILE: rtl/core/skbc_regs.sv
// ----------------------------------------------------------------------------
// Soft-knee band compressor configuration registers
// Write-only register file loaded through the index/data write port.
// ----------------------------------------------------------------------------
module skbc_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [skbc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [skbc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output skbc_pkg::cfg_t                       cfg
);

  skbc_pkg::cfg_t cfg_r;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_db  <= skbc_pkg::RST_THRESHOLD;
      cfg_r.ratio_slope   <= skbc_pkg::RST_SLOPE;
      cfg_r.knee_db       <= skbc_pkg::RST_KNEE;
      cfg_r.makeup_db     <= skbc_pkg::RST_MAKEUP;
      cfg_r.attack_coeff  <= skbc_pkg::RST_ATTACK;
      cfg_r.release_coeff <= skbc_pkg::RST_RELEASE;
      cfg_r.enable        <= skbc_pkg::RST_ENABLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        skbc_pkg::REG_THRESHOLD: cfg_r.threshold_db  <= $signed(cfg_wdata[10:0]);
        skbc_pkg::REG_SLOPE:     cfg_r.ratio_slope   <= cfg_wdata[15:0];
        skbc_pkg::REG_KNEE:      cfg_r.knee_db       <= cfg_wdata[7:0];
        skbc_pkg::REG_MAKEUP:    cfg_r.makeup_db     <= cfg_wdata[8:0];
        skbc_pkg::REG_ATTACK:    cfg_r.attack_coeff  <= cfg_wdata[23:0];
        skbc_pkg::REG_RELEASE:   cfg_r.release_coeff <= cfg_wdata[23:0];
        skbc_pkg::REG_ENABLE:    cfg_r.enable        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/skbc_datapath.sv
// ----------------------------------------------------------------------------
// Soft-knee band compressor datapath
// Envelope store, log/normalize unit, knee divider, gain and output register.
// ----------------------------------------------------------------------------
module skbc_datapath #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  skbc_pkg::in_item_t    in_data,
  input  skbc_pkg::cfg_t        cfg,
  input  skbc_pkg::dp_cmd_t     cmd,
  output skbc_pkg::dp_status_t  sts,
  output skbc_pkg::out_item_t   out_data
);

  localparam int SB        = skbc_pkg::SAMPLE_BITS;
  localparam int FB        = skbc_pkg::FRAC_BITS;
  localparam int ENV_DEPTH = (NUM_CHANNELS > 2) ? 2 : NUM_CHANNELS;
  localparam int EPW       = SB + 26;
  localparam int BW        = SB + 25;

  // Item registers.
  logic [SB-1:0]          env_r [ENV_DEPTH];
  logic                   chan_r;
  logic                   neg_r;
  logic [SB-1:0]          mag_r;
  logic [SB-1:0]          res_r;
  logic [9:0]             gr_r;
  logic signed [EPW-1:0]  eprod_r;
  logic [31:0]            nrm_r;
  logic [4:0]             lz_r;
  logic                   env_zero_r;
  logic [62:0]            mp_r;
  logic [46:0]            corr_r;
  logic [35:0]            lneg_r;
  logic [58:0]            dbp_r;
  logic signed [12:0]     x_r;
  logic [15:0]            sq_r;
  logic [27:0]            lin_r;
  logic [23:0]            cub_r;
  logic [15:0]            kk_r;
  logic [39:0]            num_r;
  logic [23:0]            rem_r;
  logic [8:0]             q_r;
  logic signed [29:0]     t_r;
  logic [48:0]            fp_r;
  logic [39:0]            c2_r;
  logic [24:0]            mant_r;
  logic [5:0]             sh_r;
  logic [BW-1:0]          big_r;
  skbc_pkg::out_item_t    out_r;

  // Intake: magnitude of the incoming sample.
  logic [SB-1:0] in_raw;
  logic          in_neg;
  logic [SB-1:0] in_mag;

  assign in_raw = in_data.in_sample;
  assign in_neg = in_raw[SB-1];
  assign in_mag = in_neg ? (~in_raw + 1'b1) : in_raw;

  // Pass-through when disabled or when the channel has no envelope.
  assign sts.bypass = !cfg.enable || (32'(in_data.chan) >= NUM_CHANNELS);

  // Envelope read for the current channel.
  logic [SB-1:0] env_cur;
  always_comb begin
    env_cur = '0;
    for (int c = 0; c < ENV_DEPTH; c++) begin
      if (chan_r == 1'(c)) begin
        env_cur = env_r[c];
      end
    end
  end

  // Envelope update: mag*2^24 + a*(env - mag), rounded.
  logic [23:0]           a_sel;
  logic signed [25:0]    a_s;
  logic signed [SB:0]    env_diff;
  logic signed [EPW-1:0] eprod_nxt;
  logic signed [EPW-1:0] env_sum;
  logic [SB-1:0]         env_new;

  assign a_sel     = (mag_r > env_cur) ? cfg.attack_coeff : cfg.release_coeff;
  assign a_s       = $signed({2'b00, a_sel});
  assign env_diff  = $signed({1'b0, env_cur}) - $signed({1'b0, mag_r});
  assign eprod_nxt = env_diff * a_s;
  assign env_sum   = $signed({2'b00, mag_r, 24'b0}) + eprod_r
                   + $signed({{(EPW-24){1'b0}}, 24'h800000});
  assign env_new   = env_sum[SB+23:24];

  // Normalize step: test and shift the top 16, 8, 4, 2 or 1 bits.
  logic [4:0] norm_sa;
  logic       norm_hit;
  assign norm_sa  = 5'd16 >> cmd.step;
  assign norm_hit = (nrm_r >> (6'd32 - {1'b0, norm_sa})) == 32'd0;

  // Log2 mantissa terms.
  logic [4:0]  msb_p;
  logic        p_ge;
  logic [30:0] m_frac;
  logic [31:0] one_m;
  logic [31:0] frac;

  assign msb_p  = 5'd31 - lz_r;
  assign p_ge   = 32'(msb_p) >= FB;
  assign m_frac = nrm_r[30:0];
  assign one_m  = 32'h8000_0000 - {1'b0, m_frac};
  assign frac   = {1'b0, m_frac} + {1'b0, corr_r[46:16]};

  // Level in 1/16 dB and its excess over the threshold.
  logic [59:0]        db_sum;
  logic [12:0]        db_mag;
  logic signed [11:0] db_lvl;
  logic signed [12:0] x_nxt;

  assign db_sum = 60'(dbp_r) + (60'(1) << 46);
  assign db_mag = db_sum[59:47];

  always_comb begin
    if (env_zero_r) begin
      db_lvl = skbc_pkg::DB_FLOOR;
    end else if (p_ge) begin
      db_lvl = '0;
    end else if (db_mag >= skbc_pkg::DB_FLOOR_MAG) begin
      db_lvl = skbc_pkg::DB_FLOOR;
    end else begin
      db_lvl = 12'(-$signed({1'b0, db_mag}));
    end
  end

  assign x_nxt = 13'(db_lvl) - 13'(cfg.threshold_db);

  assign sts.red_zero = x_r[12] || (x_r == 13'sd0);
  assign sts.in_knee  = x_r < $signed({5'b0, cfg.knee_db});

  // Reduction terms.
  logic [10:0] ux;
  logic [7:0]  ux8;
  logic [11:0] lin_d;
  logic [28:0] lsum;
  logic [11:0] gl;
  logic [40:0] nsum;
  logic [24:0] dsh;
  logic        dbit;
  logic [8:0]  q_nxt;

  assign ux    = x_r[10:0];
  assign ux8   = x_r[7:0];
  assign lin_d = {ux, 1'b0} - 12'(cfg.knee_db);
  assign lsum  = 29'(lin_r) + 29'd65536;
  assign gl    = lsum[28:17];
  assign nsum  = 41'(num_r) + {9'b0, kk_r, 16'b0};
  assign dsh   = 25'(kk_r) << (4'd8 - cmd.step);
  assign dbit  = 25'(rem_r) >= dsh;
  assign q_nxt = {q_r[7:0], dbit};

  // Gain terms.
  logic signed [10:0] g_db;
  logic [23:0]        f_frac;
  logic [BW:0]        rnd;
  logic [BW:0]        prod;
  logic [BW:0]        pmax;
  logic [BW:0]        cap;

  assign g_db   = $signed({2'b00, cfg.makeup_db}) - $signed({1'b0, gr_r});
  assign f_frac = t_r[23:0];
  assign rnd    = (BW+1)'(big_r) + ((BW+1)'(1) << (sh_r - 6'd1));
  assign prod   = rnd >> sh_r;
  assign pmax   = (BW+1)'(1) << FB;

  always_comb begin
    if (neg_r) begin
      cap = (prod > pmax) ? pmax : prod;
    end else begin
      cap = (prod > (pmax - 1'b1)) ? (pmax - 1'b1) : prod;
    end
  end

  // Envelope store, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < ENV_DEPTH; c++) begin
        env_r[c] <= '0;
      end
    end else if (cmd.op == skbc_pkg::OP_ENVW) begin
      for (int c = 0; c < ENV_DEPTH; c++) begin
        if (chan_r == 1'(c)) begin
          env_r[c] <= env_new;
        end
      end
    end
  end

  // Datapath operations, one per command.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      skbc_pkg::OP_ACCEPT: begin
        chan_r <= in_data.chan;
        neg_r  <= in_neg;
        mag_r  <= in_mag;
        res_r  <= in_raw;
        gr_r   <= '0;
      end
      skbc_pkg::OP_ENV: begin
        eprod_r <= eprod_nxt;
      end
      skbc_pkg::OP_ENVW: begin
        nrm_r      <= 32'(env_new);
        lz_r       <= '0;
        env_zero_r <= (env_new == '0);
      end
      skbc_pkg::OP_NORM: begin
        if (norm_hit) begin
          nrm_r <= nrm_r << norm_sa;
          lz_r  <= lz_r + norm_sa;
        end
      end
      skbc_pkg::OP_LOG1: begin
        mp_r <= 63'(m_frac) * 63'(one_m);
      end
      skbc_pkg::OP_LOG2: begin
        corr_r <= 47'(mp_r[62:31]) * 47'(skbc_pkg::LOG_CORR);
      end
      skbc_pkg::OP_LOG3: begin
        lneg_r <= {5'(FB) - msb_p, 31'b0} - 36'(frac);
      end
      skbc_pkg::OP_LOG4: begin
        dbp_r <= 59'(lneg_r) * 59'(skbc_pkg::DB_PER_LOG2);
      end
      skbc_pkg::OP_LOG5: begin
        x_r <= x_nxt;
      end
      skbc_pkg::OP_RED: begin
        gr_r  <= '0;
        sq_r  <= 16'(ux8) * 16'(ux8);
        lin_r <= 28'(lin_d) * 28'(cfg.ratio_slope);
      end
      skbc_pkg::OP_LIN: begin
        gr_r <= (gl > 12'(skbc_pkg::RED_MAX)) ? skbc_pkg::RED_MAX : 10'(gl);
      end
      skbc_pkg::OP_CUB: begin
        cub_r <= 24'(sq_r) * 24'(ux8);
        kk_r  <= 16'(cfg.knee_db) * 16'(cfg.knee_db);
      end
      skbc_pkg::OP_CS: begin
        num_r <= 40'(cub_r) * 40'(cfg.ratio_slope);
      end
      skbc_pkg::OP_NUM: begin
        rem_r <= nsum[40:17];
        q_r   <= '0;
      end
      skbc_pkg::OP_DIV: begin
        if (dbit) begin
          rem_r <= 24'(25'(rem_r) - dsh);
        end
        q_r  <= q_nxt;
        gr_r <= 10'(q_nxt);
      end
      skbc_pkg::OP_GAIN1: begin
        t_r <= 30'(g_db) * $signed({12'b0, skbc_pkg::LOG2_PER_DB});
      end
      skbc_pkg::OP_GAIN2: begin
        fp_r <= 49'(f_frac) * 49'(25'h100_0000 - 25'(f_frac));
      end
      skbc_pkg::OP_GAIN3: begin
        c2_r <= 40'(fp_r[48:24]) * 40'(skbc_pkg::EXP_CORR);
      end
      skbc_pkg::OP_GAIN4: begin
        mant_r <= 25'h100_0000 + 25'(f_frac) - 25'(c2_r[39:16]);
        sh_r   <= 6'd24 - t_r[29:24];
      end
      skbc_pkg::OP_MUL: begin
        big_r <= BW'(mag_r) * BW'(mant_r);
      end
      skbc_pkg::OP_SHIFT: begin
        if (neg_r) begin
          res_r <= SB'(0) - cap[SB-1:0];
        end else begin
          res_r <= cap[SB-1:0];
        end
      end
      skbc_pkg::OP_LOAD: begin
        out_r.out_sample   <= res_r;
        out_r.reduction_db <= gr_r;
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

FILE: rtl/core/skbc_ctrl.sv
// ----------------------------------------------------------------------------
// Soft-knee band compressor controller
// Sequences the datapath through envelope, log, reduction and gain steps.
// ----------------------------------------------------------------------------
module skbc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  skbc_pkg::dp_status_t  sts,
  output skbc_pkg::dp_cmd_t     cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ENV   = 5'd1;
  localparam logic [4:0] S_ENVW  = 5'd2;
  localparam logic [4:0] S_NORM  = 5'd3;
  localparam logic [4:0] S_LOG1  = 5'd4;
  localparam logic [4:0] S_LOG2  = 5'd5;
  localparam logic [4:0] S_LOG3  = 5'd6;
  localparam logic [4:0] S_LOG4  = 5'd7;
  localparam logic [4:0] S_LOG5  = 5'd8;
  localparam logic [4:0] S_RED   = 5'd9;
  localparam logic [4:0] S_LIN   = 5'd10;
  localparam logic [4:0] S_CUB   = 5'd11;
  localparam logic [4:0] S_CS    = 5'd12;
  localparam logic [4:0] S_NUM   = 5'd13;
  localparam logic [4:0] S_DIV   = 5'd14;
  localparam logic [4:0] S_GAIN1 = 5'd15;
  localparam logic [4:0] S_GAIN2 = 5'd16;
  localparam logic [4:0] S_GAIN3 = 5'd17;
  localparam logic [4:0] S_GAIN4 = 5'd18;
  localparam logic [4:0] S_MUL   = 5'd19;
  localparam logic [4:0] S_SHIFT = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  localparam logic [3:0] NORM_LAST = 4'(skbc_pkg::NORM_STEPS - 1);
  localparam logic [3:0] DIV_LAST  = 4'(skbc_pkg::DIV_STEPS - 1);

  logic [4:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd.op    = skbc_pkg::OP_NOP;
    cmd.step  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = skbc_pkg::OP_ACCEPT;
          state_nxt = sts.bypass ? S_DONE : S_ENV;
        end
      end
      S_ENV: begin
        cmd.op    = skbc_pkg::OP_ENV;
        state_nxt = S_ENVW;
      end
      S_ENVW: begin
        cmd.op    = skbc_pkg::OP_ENVW;
        step_nxt  = '0;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        cmd.op = skbc_pkg::OP_NORM;
        if (step_r == NORM_LAST) begin
          step_nxt  = '0;
          state_nxt = S_LOG1;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_LOG1: begin
        cmd.op    = skbc_pkg::OP_LOG1;
        state_nxt = S_LOG2;
      end
      S_LOG2: begin
        cmd.op    = skbc_pkg::OP_LOG2;
        state_nxt = S_LOG3;
      end
      S_LOG3: begin
        cmd.op    = skbc_pkg::OP_LOG3;
        state_nxt = S_LOG4;
      end
      S_LOG4: begin
        cmd.op    = skbc_pkg::OP_LOG4;
        state_nxt = S_LOG5;
      end
      S_LOG5: begin
        cmd.op    = skbc_pkg::OP_LOG5;
        state_nxt = S_RED;
      end
      S_RED: begin
        cmd.op = skbc_pkg::OP_RED;
        if (sts.red_zero) begin
          state_nxt = S_GAIN1;
        end else if (sts.in_knee) begin
          state_nxt = S_CUB;
        end else begin
          state_nxt = S_LIN;
        end
      end
      S_LIN: begin
        cmd.op    = skbc_pkg::OP_LIN;
        state_nxt = S_GAIN1;
      end
      S_CUB: begin
        cmd.op    = skbc_pkg::OP_CUB;
        state_nxt = S_CS;
      end
      S_CS: begin
        cmd.op    = skbc_pkg::OP_CS;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.op    = skbc_pkg::OP_NUM;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = skbc_pkg::OP_DIV;
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = S_GAIN1;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_GAIN1: begin
        cmd.op    = skbc_pkg::OP_GAIN1;
        state_nxt = S_GAIN2;
      end
      S_GAIN2: begin
        cmd.op    = skbc_pkg::OP_GAIN2;
        state_nxt = S_GAIN3;
      end
      S_GAIN3: begin
        cmd.op    = skbc_pkg::OP_GAIN3;
        state_nxt = S_GAIN4;
      end
      S_GAIN4: begin
        cmd.op    = skbc_pkg::OP_GAIN4;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = skbc_pkg::OP_MUL;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.op    = skbc_pkg::OP_SHIFT;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.op    = skbc_pkg::OP_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    if (cmd.op == skbc_pkg::OP_LOAD) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // A result is never written over one that has not been taken.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == skbc_pkg::OP_LOAD) |-> (!out_valid_r || out_ready))
    else $error("result loaded while output register still occupied");

  // The step counter stays within the longest iteration.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= DIV_LAST)
    else $error("step counter out of range");

  // A passed-through item goes straight to result hand-over.
  a_bypass_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.bypass) |=> (state_r == S_DONE))
    else $error("bypassed item did not go to hand-over");

  // A compressed item starts with the envelope update.
  a_env_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !sts.bypass) |=> (state_r == S_ENV))
    else $error("compressed item did not start envelope update");

endmodule

FILE: rtl/core/soft_knee_band_compressor_core.sv
// Path from input accept to out_valid: a disabled item or one whose channel is
// out of range goes straight to hand-over; others pass the envelope update, the
// 5-step normalize and the chained log and gain multipliers, with a linear step
// above the knee and the 9-step restoring divider inside it.
// One item is in work at a time; the next is accepted the cycle after the
// result enters the output register. Reset clears envelopes and control state.
// ----------------------------------------------------------------------------
// Soft-knee band compressor core
// Per-channel peak envelope, log-domain soft-knee gain computer and gain stage.
// ----------------------------------------------------------------------------
module soft_knee_band_compressor_core #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  skbc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output skbc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [skbc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [skbc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  skbc_pkg::cfg_t       cfg;
  skbc_pkg::dp_cmd_t    cmd;
  skbc_pkg::dp_status_t sts;

  // Configuration registers.
  skbc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer.
  skbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  skbc_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

FILE: tb/soft_knee_band_compressor_core_tb.sv
// ----------------------------------------------------------------------------
// Soft-knee band compressor core testbench
// Drives samples and register settings into the core, predicts every result
// with a local fixed-point model of the envelope, level, gain computer and
// gain stage, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module soft_knee_band_compressor_core_tb;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  skbc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  skbc_pkg::out_item_t out_data;
  logic                cfg_we;
  logic [skbc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [skbc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

  // Predictor copy of the register file and channel envelopes.
  logic signed [10:0] cur_threshold;
  logic [15:0]        cur_slope;
  logic [7:0]         cur_knee;
  logic [8:0]         cur_makeup;
  logic [23:0]        cur_attack;
  logic [23:0]        cur_release;
  logic               cur_enable;
  logic [23:0]        env_level [2];

  skbc_pkg::out_item_t expected_results [$];
  int        error_count;
  int        idle_cycles;
  bit        calm_mode;
  bit        rx_hold;
  bit        tx_idle_en;

  soft_knee_band_compressor_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a period of two units.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Envelope magnitude to level in 1/16 dB, floored at -100 dB.
  function automatic int signed level_db(input logic [23:0] e);
    int      msb;
    longint unsigned m, frac, negv, db;
    msb = 0;
    if (e == 0) return -1600;
    for (int b = 0; b < 24; b++) if (e[b]) msb = b;
    m = ((longint'(e) << (31 - msb)) & 64'hFFFF_FFFF) - (64'd1 << 31);
    frac = m + ((((m * ((64'd1 << 31) - m)) >> 31) * 64'd22713) >> 16);
    if (msb >= 23) return 0;
    negv = (longint'(23 - msb) << 31) - frac;
    db = (negv * 64'd6313041 + (64'd1 << 46)) >> 47;
    if (db >= 1600) return -1600;
    return -int'(db);
  endfunction

  // Soft-knee gain reduction from a level, saturated to 60 dB.
  function automatic int unsigned knee_reduction(input int signed db);
    longint signed   x;
    longint unsigned ux, k, s, den, gr;
    x = longint'(db) - longint'(cur_threshold);
    k = cur_knee;
    s = cur_slope;
    if (x <= 0) return 0;
    ux = x;
    if (ux < k) begin
      den = k * k * 64'd131072;
      gr = (ux * ux * ux * s + den / 2) / den;
    end else begin
      gr = ((2 * ux - k) * s + 64'd65536) >> 17;
    end
    return (gr > 960) ? 960 : int'(gr);
  endfunction

  // Works out the compressed sample and updates the channel envelope.
  function automatic skbc_pkg::out_item_t compress_sample(input skbc_pkg::in_item_t item);
    skbc_pkg::out_item_t res;
    longint unsigned mag, a, envv, f, mant, prod, u;
    longint signed   t;
    int              ipart, sh;
    int unsigned     gr;
    bit              neg;
    neg = item.in_sample[23];
    mag = neg ? (64'd1 << 24) - longint'(item.in_sample[23:0]) : item.in_sample[23:0];
    if (!cur_enable) begin
      res.out_sample   = item.in_sample;
      res.reduction_db = '0;
      return res;
    end
    envv = env_level[item.chan];
    a = (mag > envv) ? cur_attack : cur_release;
    envv = (a * envv + ((64'd1 << 24) - a) * mag + (64'd1 << 23)) >> 24;
    env_level[item.chan] = envv[23:0];
    gr = knee_reduction(level_db(envv[23:0]));
    t = (longint'(cur_makeup) - longint'(gr)) * 174165;
    u = t + (64'sd16 <<< 24);
    ipart = int'(u >> 24) - 16;
    f = u & 64'hFF_FFFF;
    mant = (64'd1 << 24) + f - ((((f * ((64'd1 << 24) - f)) >> 24) * 64'd22489) >> 16);
    sh = 24 - ipart;
    prod = (mag * mant + (64'd1 << (sh - 1))) >> sh;
    if (neg) begin
      if (prod > 64'd8388608) prod = 64'd8388608;
      res.out_sample = 24'((64'd1 << 24) - prod);
    end else begin
      if (prod > 64'd8388607) prod = 64'd8388607;
      res.out_sample = 24'(prod);
    end
    res.reduction_db = gr[9:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Writes one register in the core and in the predictor; the caller drops the enable.
  task automatic write_reg(input logic [skbc_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      skbc_pkg::REG_THRESHOLD: cur_threshold = val[10:0];
      skbc_pkg::REG_SLOPE:     cur_slope     = val[15:0];
      skbc_pkg::REG_KNEE:      cur_knee      = val[7:0];
      skbc_pkg::REG_MAKEUP:    cur_makeup    = val[8:0];
      skbc_pkg::REG_ATTACK:    cur_attack    = val;
      skbc_pkg::REG_RELEASE:   cur_release   = val;
      skbc_pkg::REG_ENABLE:    cur_enable    = val[0];
      default: ;
    endcase
  endtask

  // Stops offering items, waits until all results are back, then lets the core settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_all(input int thr, input int slope, input int knee, input int makeup,
                         input int att, input int rel, input bit en);
    drain_results();
    write_reg(skbc_pkg::REG_THRESHOLD, 24'(thr));
    write_reg(skbc_pkg::REG_SLOPE, 24'(slope));
    write_reg(skbc_pkg::REG_KNEE, 24'(knee));
    write_reg(skbc_pkg::REG_MAKEUP, 24'(makeup));
    write_reg(skbc_pkg::REG_ATTACK, 24'(att));
    write_reg(skbc_pkg::REG_RELEASE, 24'(rel));
    write_reg(skbc_pkg::REG_ENABLE, 24'(en));
    cfg_we <= 1'b0;
  endtask

  // Sends one item, with an optional random gap before it.
  task automatic send_item(input bit chan, input logic [23:0] smp);
    skbc_pkg::in_item_t item;
    if (tx_idle_en && !calm_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item.chan      = chan;
    item.in_sample = smp;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(compress_sample(item));
  endtask

  function automatic logic [23:0] random_sample();
    case ($urandom_range(0, 4))
      0: return 24'($urandom_range(0, 255)) - 24'd128;
      1: return 24'($urandom);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom_range(0, 65535)) << $urandom_range(0, 8);
    endcase
  endfunction

  task automatic test_directed_extremes();
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'h7FFFFF);
    send_item(1'b0, 24'h800000);
    send_item(1'b1, 24'h800000);
    send_item(1'b1, 24'h000001);
    send_item(1'b1, 24'hFFFFFF);
    send_item(1'b0, 24'h000100);
    send_item(1'b1, 24'h400000);
  endtask

  task automatic test_knee_and_ranges();
    // Fast envelope so the level follows the sample and walks the knee.
    set_all(-160, 62259, 192, 384, 0, 0, 1'b1);
    for (int k = 0; k < 6; k++) send_item(k[0], 24'h001000 << (2 * k));
    // Zero knee takes the linear branch; threshold at both extremes.
    set_all(-960, 65535, 0, 511, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_item(1'b0, 24'h7FFFFF);
    send_item(1'b1, 24'h800000);
    set_all(-1024, 65535, 255, 0, 0, 0, 1'b1);
    send_item(1'b0, 24'h800000);
    send_item(1'b1, 24'h000003);
    set_all(1023, 0, 1, 0, 0, 0, 1'b1);
    send_item(1'b0, 24'h7FFFFF);
    // Bypass.
    set_all(0, 0, 0, 0, 0, 0, 1'b0);
    send_item(1'b0, 24'h800000);
    send_item(1'b1, 24'h123456);
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      set_all(-$urandom_range(0, 960), $urandom_range(0, 65535), $urandom_range(0, 255),
              $urandom_range(0, 511), $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(
              16000000, 16777215), $urandom_range(0, 3) == 0 ? $urandom :
              $urandom_range(16000000, 16777215), $urandom_range(0, 7) != 0);
      for (int n = 0; n < per_phase; n++) send_item($urandom_range(0, 1), random_sample());
    end
  endtask

  // Receiver holds off while the sender keeps offering; then the sender waits.
  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        for (int n = 0; n < 6; n++) send_item($urandom_range(0, 1), random_sample());
      end
      begin
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
    join
    drain_results();
  endtask

  // Result side: random stalls and field checks.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", out_data.out_sample, 0);
        end else begin
          skbc_pkg::out_item_t want;
          want = expected_results.pop_front();
          if (out_data.out_sample !== want.out_sample)
            report_mismatch("out_sample", out_data.out_sample, want.out_sample);
          if (out_data.reduction_db !== want.reduction_db)
            report_mismatch("reduction_db", out_data.reduction_db, want.reduction_db);
        end
      end
      if (rx_hold) out_ready <= 1'b0;
      else if (calm_mode) out_ready <= 1'b1;
      else if (idle_cycles > 0) out_ready <= 1'b0;
      else out_ready <= 1'b1;
    end
  end

  // Burst counter for receiver stalls.
  always @(posedge clk) begin
    if (idle_cycles > 0) idle_cycles <= idle_cycles - 1;
    else if ($urandom_range(0, 5) == 0) idle_cycles <= $urandom_range(1, 7);
  end

  // Watchdog: cycles with no accepted item on either side and no register write.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet > 5000) begin
        $display("soft_knee_band_compressor_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    calm_mode   = 1'b0;
    rx_hold     = 1'b0;
    tx_idle_en  = 1'b1;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    cur_threshold = skbc_pkg::RST_THRESHOLD;
    cur_slope     = skbc_pkg::RST_SLOPE;
    cur_knee      = skbc_pkg::RST_KNEE;
    cur_makeup    = skbc_pkg::RST_MAKEUP;
    cur_attack    = skbc_pkg::RST_ATTACK;
    cur_release   = skbc_pkg::RST_RELEASE;
    cur_enable    = skbc_pkg::RST_ENABLE;
    env_level[0]  = '0;
    env_level[1]  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_knee_and_ranges();
    test_backpressure();
    test_random_settings(12, 110);
    calm_mode = 1'b1;
    test_random_settings(2, 100);
    drain_results();
    if (error_count == 0) begin
      $display("soft_knee_band_compressor_core regression: pass");
    end else begin
      $display("soft_knee_band_compressor_core regression: fail");
    end
    $finish;
  end

endmodule
